### hdl/sigmoid_neuron_unit_top_macros.svh
// Assertion macros for the files that check their own logic.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef SIGMOID_NEURON_UNIT_TOP_MACROS_SVH
`define SIGMOID_NEURON_UNIT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SNU_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sigmoid neuron unit: assertion failed");
`define SNU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sigmoid neuron unit: assertion failed");
`else
`define SNU_ASSERT_SAME(label, ante, cons)
`define SNU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hdl/snu_pkg.sv
package snu_pkg;

	typedef enum logic [1:0] {
		OP_INPUT = 2'd0,
		OP_EVAL  = 2'd1,
		OP_ERROR = 2'd2,
		OP_ROUND = 2'd3
	} snu_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_ACC,
		S_DELTA,
		S_POS,
		S_RD0,
		S_RD1,
		S_INT,
		S_SIG,
		S_DMUL,
		S_DER,
		S_OUT
	} snu_state_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [15:0] weight;
		logic signed [15:0] input_value;
		logic signed [15:0] error_value;
	} item_t;

	typedef struct packed {
		logic [15:0]        output_value;
		logic [14:0]        err_modifier;
		logic signed [23:0] delta_value;
		logic               phase_fault;
	} result_t;

	localparam int MUL_A_W = 18;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic signed [25:0] SUM_MAX = 26'sd8388607;
	localparam logic signed [25:0] SUM_MIN = -26'sd8388608;

	// Clamp a widened sum back to the signed 24-bit Q12.12 range.
	function automatic logic signed [23:0] snu_sat24(input logic signed [25:0] v);
		logic signed [23:0] r;
		if (v > SUM_MAX) begin
			r = SUM_MAX[23:0];
		end else if (v < SUM_MIN) begin
			r = SUM_MIN[23:0];
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	// Shift-subtract division, used only to build constants at elaboration.
	function automatic logic [63:0] snu_udiv(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// e^-a in Q0.30 for a in Q12.12: Taylor series at a/16, then four squarings.
	function automatic logic [63:0] snu_exp_neg(input logic [63:0] a);
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] prod;
		logic [63:0] r;
		logic signed [63:0] acc;
		y = a << 14;
		term = 64'd1 << 30;
		acc = 64'sd1 <<< 30;
		for (int i = 1; i <= 10; i++) begin
			prod = term * y;
			term = snu_udiv(prod >> 30, 64'(i));
			if (i[0]) begin
				acc = acc - $signed(term);
			end else begin
				acc = acc + $signed(term);
			end
		end
		r = (acc > 64'sd0) ? 64'(acc) : 64'd0;
		for (int i = 0; i < 4; i++) begin
			r = (r * r + (64'd1 << 29)) >> 30;
		end
		return r;
	endfunction

	// Table sample k of a table with the given depth, Q0.16, capped at 65535.
	function automatic logic [15:0] snu_sig_sample(input int unsigned k, input int unsigned depth);
		logic signed [63:0] x;
		logic [63:0] mag;
		logic [63:0] e;
		logic [63:0] d;
		logic [63:0] s;
		x = $signed(snu_udiv(64'(k) * 64'd65536, 64'(depth))) - 64'sd32768;
		mag = (x < 64'sd0) ? 64'(-x) : 64'(x);
		e = snu_exp_neg(mag);
		d = (64'd1 << 30) + e;
		if (x >= 64'sd0) begin
			s = snu_udiv((64'd1 << 46) + (d >> 1), d);
		end else begin
			s = snu_udiv((e << 16) + (d >> 1), d);
		end
		return (s > 64'd65535) ? 16'hFFFF : s[15:0];
	endfunction

	// Derivative of the interpolated sigmoid at an input sum of zero.
	function automatic logic [14:0] snu_deriv_at_zero(input int unsigned depth);
		logic [63:0] pos;
		logic [63:0] idx;
		logic [63:0] f;
		logic [63:0] t0;
		logic [63:0] t1;
		logic [63:0] s;
		logic [63:0] d;
		pos = 64'd32768 * 64'(depth);
		idx = pos >> 16;
		f = pos & 64'hFFFF;
		t0 = 64'(snu_sig_sample(32'(idx), depth));
		t1 = 64'(snu_sig_sample(32'(idx + 64'd1), depth));
		s = (t0 * (64'd65536 - f) + t1 * f + 64'd32768) >> 16;
		d = (s * (64'd65536 - s) + 64'd32768) >> 16;
		return d[14:0];
	endfunction

endpackage

### hdl/snu_item_if.sv
interface snu_item_if;
	import snu_pkg::*;

	logic  valid;
	logic  ready;
	item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### hdl/snu_result_if.sv
interface snu_result_if;
	import snu_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### hdl/sigmoid_neuron_unit_top.sv
// Channel   Port     Direction  Payload
// request   item     in         operation, weight, input_value, error_value
// result    result   out        output_value, err_modifier, delta_value, phase_fault
//
// One request is taken at a time and yields exactly one result.
// A weighted input, or a new round outside the forward phase, forms its product and
// then reruns the sigmoid and its derivative; an output evaluation in the forward
// phase runs only the sigmoid and its derivative; the rest go to the result.
// The steps are set by the single registered 18x25 multiplier, which is used for
// up to four products per request, and by one sigmoid table read per cycle.
// Reset (arst_n low) returns the sums, latches and phase to their initial values
// at once; there is no table initialization pass.
// A stalled result holds in its output register; the next result waits for it.
`include "sigmoid_neuron_unit_top_macros.svh"

module sigmoid_neuron_unit_top #(
	parameter int SIGMOID_TABLE_DEPTH = 256
) (
	input logic          clk,
	input logic          arst_n,
	snu_item_if.sink     item,
	snu_result_if.source result
);
	import snu_pkg::*;

	localparam int AW = $clog2(SIGMOID_TABLE_DEPTH + 1);
	localparam logic [14:0] DERIV_RESET = snu_deriv_at_zero(SIGMOID_TABLE_DEPTH);

	snu_state_t state_q, state_d;

	// Neuron state visible in the results.
	logic signed [23:0] input_sum_q;
	logic signed [23:0] error_sum_q;
	logic [15:0]        out_latch_q;
	logic signed [23:0] delta_q;
	logic               fwd_q;
	logic [14:0]        deriv_q;
	logic               fault_q;

	// Request payload captured at acceptance.
	logic [1:0]         op_q;
	logic signed [15:0] w_q;
	logic signed [15:0] v_q;
	logic signed [15:0] e_q;

	// Sigmoid evaluation working registers.
	logic          lo_q;
	logic          hi_q;
	logic          clamp_q;
	logic [AW-1:0] idx_q;
	logic [15:0]   f_q;
	logic [15:0]   t0_q;
	logic [15:0]   t1_q;
	logic [15:0]   s_q;

	logic              res_valid_q;
	result_t           res_q;

	logic                       accept;
	logic                       load;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [MUL_P_W-1:0]  prod_q;
	logic [AW-1:0]              rom_addr;
	logic [15:0]                rom_data;

	// Derived datapath values.
	logic signed [24:0]        u_pos;
	logic [AW-1:0]             idx_now;
	logic signed [MUL_P_W-1:0] rnd_12;
	logic signed [MUL_P_W-1:0] rnd_16;
	logic signed [25:0]        acc_sum;
	logic signed [25:0]        err_sum;
	logic signed [25:0]        delta_sum;
	logic signed [33:0]        interp;
	logic [15:0]               sig_now;
	logic signed [16:0]        t_diff;

	assign accept = item.valid && item.ready;

	snu_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	snu_sig_rom #(
		.DEPTH (SIGMOID_TABLE_DEPTH),
		.AW    (AW)
	) u_rom (
		.addr (rom_addr),
		.data (rom_data)
	);

	always_comb begin
		u_pos     = 25'(input_sum_q) + 25'sd32768;
		rnd_12    = prod_q + MUL_P_W'(2048);
		rnd_16    = prod_q + MUL_P_W'(32768);
		acc_sum   = 26'(input_sum_q) + $signed(rnd_12[37:12]);
		err_sum   = 26'(error_sum_q) + 26'(e_q);
		delta_sum = $signed(rnd_16[41:16]);
		interp    = $signed({2'b00, t0_q, 16'h0000}) + $signed(prod_q[33:0]) + 34'sd32768;
		sig_now   = (interp[33:32] != 2'b00) ? 16'hFFFF : interp[31:16];
		t_diff    = $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});
		if (lo_q) begin
			idx_now = '0;
		end else if (hi_q) begin
			idx_now = AW'(SIGMOID_TABLE_DEPTH);
		end else begin
			idx_now = prod_q[16 +: AW];
		end
		// One table read per cycle: the lower sample first, then its neighbor.
		if (state_q == S_RD0) begin
			rom_addr = idx_now;
		end else begin
			rom_addr = clamp_q ? idx_q : AW'(idx_q + 1'b1);
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_DISP: begin
				if (op_q == OP_INPUT) begin
					mul_a = MUL_A_W'(w_q);
					mul_b = MUL_B_W'(v_q);
				end else begin
					mul_a = MUL_A_W'({1'b0, deriv_q});
					mul_b = MUL_B_W'(error_sum_q);
				end
			end
			S_POS: begin
				mul_a = MUL_A_W'(SIGMOID_TABLE_DEPTH);
				mul_b = MUL_B_W'({1'b0, u_pos[15:0]});
			end
			S_INT: begin
				mul_a = MUL_A_W'(t_diff);
				mul_b = MUL_B_W'({1'b0, f_q});
			end
			S_DMUL: begin
				mul_a = MUL_A_W'({1'b0, s_q});
				mul_b = MUL_B_W'({1'b0, 17'd65536 - {1'b0, s_q}});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: a weighted input goes through the product and accumulation,
	// then every change of the input sum reruns the sigmoid and its derivative.
	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		load       = 1'b0;
		case (state_q)
			S_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (op_q)
					OP_INPUT: state_d = S_ACC;
					OP_EVAL:  state_d = fwd_q ? S_POS : S_OUT;
					OP_ERROR: state_d = S_OUT;
					OP_ROUND: state_d = fwd_q ? S_OUT : S_DELTA;
					default:  state_d = S_OUT;
				endcase
			end
			S_ACC:   state_d = S_POS;
			S_DELTA: state_d = S_POS;
			S_POS:   state_d = S_RD0;
			S_RD0:   state_d = S_RD1;
			S_RD1:   state_d = S_INT;
			S_INT:   state_d = S_SIG;
			S_SIG:   state_d = S_DMUL;
			S_DMUL:  state_d = S_DER;
			S_DER:   state_d = S_OUT;
			S_OUT: begin
				if (!res_valid_q || result.ready) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_sum_q <= '0;
			error_sum_q <= '0;
			out_latch_q <= '0;
			delta_q     <= '0;
			fwd_q       <= 1'b1;
			deriv_q     <= DERIV_RESET;
			fault_q     <= 1'b0;
		end else begin
			case (state_q)
				S_DISP: begin
					fault_q <= (op_q == OP_ROUND) && fwd_q;
					if (op_q == OP_ERROR) begin
						error_sum_q <= snu_sat24(err_sum);
					end
				end
				S_ACC: begin
					input_sum_q <= snu_sat24(acc_sum);
				end
				S_DELTA: begin
					delta_q     <= snu_sat24(delta_sum);
					input_sum_q <= '0;
					error_sum_q <= '0;
					out_latch_q <= '0;
					fwd_q       <= 1'b1;
				end
				S_SIG: begin
					if (op_q == OP_EVAL) begin
						out_latch_q <= sig_now;
						fwd_q       <= 1'b0;
					end
				end
				S_DER: begin
					deriv_q <= rnd_16[30:16];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= item.data.operation;
			w_q  <= item.data.weight;
			v_q  <= item.data.input_value;
			e_q  <= item.data.error_value;
		end
		if (state_q == S_POS) begin
			lo_q <= u_pos[24];
			hi_q <= !u_pos[24] && (u_pos[23:16] != 8'h00);
		end
		if (state_q == S_RD0) begin
			idx_q   <= idx_now;
			f_q     <= (lo_q || hi_q) ? 16'h0000 : prod_q[15:0];
			clamp_q <= lo_q || hi_q;
			t0_q    <= rom_data;
		end
		if (state_q == S_RD1) begin
			t1_q <= rom_data;
		end
		if (state_q == S_SIG) begin
			s_q <= sig_now;
		end
		if (load) begin
			res_q.output_value <= out_latch_q;
			res_q.err_modifier <= deriv_q;
			res_q.delta_value  <= delta_q;
			res_q.phase_fault  <= fault_q;
		end
	end

	// The result register frees the sequencer as soon as the result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	`SNU_ASSERT_NEXT(a_busy_after_accept, accept, !item.ready)
	`SNU_ASSERT_SAME(a_fault_only_forward_round, load && fault_q, (op_q == OP_ROUND) && fwd_q)
	`SNU_ASSERT_SAME(a_deriv_in_range, 1'b1, deriv_q <= 15'd16384)
	`SNU_ASSERT_SAME(a_forward_from_round, $rose(fwd_q), $past(state_q) == S_DELTA)
endmodule

### hdl/snu_mul.sv
module snu_mul (
	input  logic                                clk,
	input  logic signed [snu_pkg::MUL_A_W-1:0] a,
	input  logic signed [snu_pkg::MUL_B_W-1:0] b,
	output logic signed [snu_pkg::MUL_P_W-1:0] p_q
);
	import snu_pkg::*;

	// Product is registered every cycle; the sequencer picks it up in the state after the one that drove the operands.
	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a * b);
	end
endmodule

### hdl/snu_sig_rom.sv
module snu_sig_rom #(
	parameter int DEPTH = 256,
	parameter int AW    = 9
) (
	input  logic [AW-1:0] addr,
	output logic [15:0]   data
);
	import snu_pkg::*;

	logic [15:0] samples [0:DEPTH];

	// Every sample is a constant worked out at elaboration.
	for (genvar k = 0; k <= DEPTH; k++) begin : g_sample
		localparam logic [15:0] SAMPLE = snu_sig_sample(k, DEPTH);
		assign samples[k] = SAMPLE;
	end

	assign data = (int'(addr) <= DEPTH) ? samples[addr] : 16'h0000;
endmodule
